[rtl/core/acdm_pkg.sv]
// acdm_pkg: shared codes and default sizes for the dna pattern matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package acdm_pkg;
    localparam int FUNC_W    = 2;
    localparam int SYM_W     = 2;
    localparam int MATCH_W   = 8;
    localparam int TOTAL_W   = 32;
    localparam int MAX_NODES_DEF = 4096;
    localparam int ALPHA_DEF     = 4;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd3;
endpackage
`default_nettype wire

[rtl/core/acdm_ram.sv]
// acdm_ram: single write, single read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module acdm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/aho_corasick_dna_matcher.sv]
// aho_corasick_dna_matcher: trie, failure link build and text scan sequencer
// depends on acdm_pkg and acdm_ram (node table and breadth-first queue)
//
// One item at a time. Insert, scan and build step through states whose pace is
// set by the registered read data of the node table's single read port: every
// trie step is one read, and each failure link followed adds one more read. A
// symbol outside the alphabet ends a scan or an insert straight from idle, as a
// clear always does. Root children sit in flip-flops and every other node row
// is written when the node is allocated, so no clearing pass follows reset or
// clear. A new item is taken once the previous result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module aho_corasick_dna_matcher #(
    parameter int MAX_NODES     = acdm_pkg::MAX_NODES_DEF,
    parameter int ALPHABET_SIZE = acdm_pkg::ALPHA_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [acdm_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [acdm_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic                          i_last_of_pattern,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [acdm_pkg::MATCH_W-1:0]       o_matches_here,
    output logic [acdm_pkg::TOTAL_W-1:0]       o_running_total,
    output logic                               o_table_full,
    output logic                               o_done_res
);
    import acdm_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NC_W   = NODE_W + 1;
    localparam int CI_W   = $clog2(ALPHABET_SIZE);

    typedef struct packed {
        logic [ALPHABET_SIZE-1:0][NODE_W-1:0] ch;
        logic                                 endm;
        logic [NODE_W-1:0]                    fail;
        logic [MATCH_W-1:0]                   match;
    } t_row;
    localparam int ROW_W = $bits(t_row);

    typedef enum logic [3:0] {
        S_IDLE, S_I_DEC, S_I_PAR, S_I_END, S_SC_CHK, S_SC_ROW, S_SC_MATCH,
        S_B_CHILD, S_B_GX, S_B_GROW, S_B_FRD, S_B_NROW, S_B_QRD, S_B_CROW
    } t_state;

    t_state r_state, n_state;
    logic r_o_valid, n_o_valid;
    logic [MATCH_W-1:0] r_out_m, n_out_m;
    logic r_out_done, n_out_done;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [NC_W-1:0] r_node_count, n_node_count;
    logic [NODE_W-1:0] r_cursor, n_cursor, r_scan, n_scan;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic r_full, n_full, r_lost, n_lost;
    logic [ALPHABET_SIZE-1:0][NODE_W-1:0] r_root, n_root;
    logic [NC_W-1:0] r_head, n_head, r_tail, n_tail;

    logic [SYM_W-1:0] r_sym, n_sym;
    logic r_last, n_last;
    logic [NODE_W-1:0] r_x, n_x, r_c, n_c, r_cur, n_cur, r_cur_fail, n_cur_fail;
    logic [NODE_W-1:0] r_f, n_f;
    logic [MATCH_W-1:0] r_fm, n_fm;
    logic [ALPHABET_SIZE-1:0][NODE_W-1:0] r_cur_ch, n_cur_ch;
    logic [CI_W:0] r_i, n_i;
    t_row r_prow, n_prow;

    logic m_we;
    logic [NODE_W-1:0] m_waddr, m_raddr;
    logic [ROW_W-1:0] m_wdata, m_rdata;
    logic q_we;
    logic [NODE_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    t_row w_row;

    assign w_row = t_row'(m_rdata);

    acdm_ram #(.DEPTH(MAX_NODES), .WIDTH(ROW_W)) u_node_ram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    acdm_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    assign o_ready         = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign o_valid         = r_o_valid;
    assign o_matches_here  = r_out_m;
    assign o_running_total = r_total;
    assign o_table_full    = r_full;
    assign o_done_res      = r_out_done;

    always_comb begin
        t_row v_row;
        logic [NODE_W-1:0] v_c;
        logic [MATCH_W:0] v_msum;
        logic [TOTAL_W:0] v_tsum;
        logic [CI_W-1:0] v_si, v_ii;
        logic v_symok;

        n_state = r_state; n_o_valid = r_o_valid; n_out_m = r_out_m;
        n_out_done = r_out_done; n_func = r_func; n_node_count = r_node_count;
        n_cursor = r_cursor; n_scan = r_scan; n_total = r_total; n_full = r_full;
        n_lost = r_lost; n_root = r_root; n_head = r_head; n_tail = r_tail;
        n_sym = r_sym; n_last = r_last; n_x = r_x; n_c = r_c; n_cur = r_cur;
        n_cur_fail = r_cur_fail; n_f = r_f; n_fm = r_fm; n_cur_ch = r_cur_ch;
        n_i = r_i; n_prow = r_prow;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        v_row = w_row;
        v_c = '0;
        v_msum = '0;
        v_tsum = '0;
        v_si = r_sym[CI_W-1:0];
        v_ii = r_i[CI_W-1:0];
        v_symok = ({1'b0, i_symbol} < 3'(ALPHABET_SIZE));

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_func = i_func;
                    n_sym  = i_symbol;
                    n_last = i_last_of_pattern;
                    n_out_m = '0;
                    case (i_func)
                        FUNC_CLEAR: begin
                            n_node_count = NC_W'(1);
                            n_cursor = '0; n_scan = '0; n_total = '0;
                            n_full = 1'b0; n_lost = 1'b0; n_root = '0;
                            n_o_valid = 1'b1; n_out_done = 1'b1;
                        end
                        FUNC_INSERT: begin
                            if (!v_symok) begin
                                n_o_valid = 1'b1; n_out_done = 1'b0;
                            end else if (r_lost) begin
                                if (i_last_of_pattern) begin
                                    n_lost = 1'b0; n_cursor = '0;
                                end
                                n_o_valid = 1'b1; n_out_done = 1'b0;
                            end else begin
                                m_raddr = r_cursor;
                                n_state = S_I_DEC;
                            end
                        end
                        FUNC_BUILD: begin
                            n_cur = '0; n_cur_ch = r_root; n_i = '0;
                            n_head = '0; n_tail = '0;
                            n_state = S_B_CHILD;
                        end
                        default: begin
                            if (!v_symok) begin
                                n_scan = '0;
                                n_o_valid = 1'b1; n_out_done = 1'b1;
                            end else begin
                                n_x = r_scan;
                                n_state = S_SC_CHK;
                            end
                        end
                    endcase
                end
            end
            S_I_DEC: begin
                v_c = (r_cursor == '0) ? r_root[v_si] : w_row.ch[v_si];
                n_prow = w_row;
                if (v_c != '0) begin
                    if (r_last) begin
                        m_raddr = v_c; n_c = v_c; n_state = S_I_END;
                    end else begin
                        n_cursor = v_c;
                        n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
                    end
                end else if (r_node_count >= NC_W'(MAX_NODES)) begin
                    n_full = 1'b1; n_cursor = '0; n_lost = !r_last;
                    n_o_valid = 1'b1; n_out_done = 1'b0; n_state = S_IDLE;
                end else begin
                    v_row = '0;
                    v_row.endm = r_last;
                    m_we = 1'b1; m_waddr = r_node_count[NODE_W-1:0];
                    m_wdata = ROW_W'(v_row);
                    n_node_count = r_node_count + NC_W'(1);
                    n_c = r_node_count[NODE_W-1:0];
                    if (r_cursor == '0) begin
                        n_root[v_si] = r_node_count[NODE_W-1:0];
                        n_cursor = r_last ? '0 : r_node_count[NODE_W-1:0];
                        n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_state = S_I_PAR;
                    end
                end
            end
            S_I_PAR: begin
                v_row = r_prow;
                v_row.ch[v_si] = r_c;
                m_we = 1'b1; m_waddr = r_cursor; m_wdata = ROW_W'(v_row);
                n_cursor = r_last ? '0 : r_c;
                n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
            end
            S_I_END: begin
                v_row = w_row;
                v_row.endm = 1'b1;
                m_we = 1'b1; m_waddr = r_c; m_wdata = ROW_W'(v_row);
                n_cursor = '0;
                n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
            end
            S_SC_CHK: begin
                if (r_x == '0) begin
                    v_c = r_root[v_si];
                    if (v_c != '0) begin
                        n_x = v_c; m_raddr = v_c; n_state = S_SC_MATCH;
                    end else begin
                        n_scan = '0;
                        n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    m_raddr = r_x; n_state = S_SC_ROW;
                end
            end
            S_SC_ROW: begin
                v_c = w_row.ch[v_si];
                if (v_c != '0) begin
                    n_x = v_c; m_raddr = v_c; n_state = S_SC_MATCH;
                end else begin
                    n_x = w_row.fail; n_state = S_SC_CHK;
                end
            end
            S_SC_MATCH: begin
                v_tsum = {1'b0, r_total} + (TOTAL_W+1)'(w_row.match);
                n_total = v_tsum[TOTAL_W] ? '1 : v_tsum[TOTAL_W-1:0];
                n_scan = r_x;
                n_out_m = w_row.match;
                n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
            end
            S_B_CHILD: begin
                if (r_i == (CI_W+1)'(ALPHABET_SIZE)) begin
                    if (r_head < r_tail) begin
                        q_raddr = r_head[NODE_W-1:0];
                        n_head = r_head + NC_W'(1);
                        n_state = S_B_QRD;
                    end else begin
                        n_scan = '0;
                        n_o_valid = 1'b1; n_out_done = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    v_c = r_cur_ch[v_ii];
                    if (v_c == '0) begin
                        n_i = r_i + (CI_W+1)'(1);
                    end else begin
                        n_c = v_c;
                        if (r_cur == '0) begin
                            n_f = '0; n_fm = '0; m_raddr = v_c; n_state = S_B_NROW;
                        end else begin
                            n_x = r_cur_fail; n_state = S_B_GX;
                        end
                    end
                end
            end
            S_B_GX: begin
                if (r_x == '0) begin
                    v_c = r_root[v_ii];
                    if (v_c != '0) begin
                        n_f = v_c; m_raddr = v_c; n_state = S_B_FRD;
                    end else begin
                        n_f = '0; n_fm = '0; m_raddr = r_c; n_state = S_B_NROW;
                    end
                end else begin
                    m_raddr = r_x; n_state = S_B_GROW;
                end
            end
            S_B_GROW: begin
                v_c = w_row.ch[v_ii];
                if (v_c != '0) begin
                    n_f = v_c; m_raddr = v_c; n_state = S_B_FRD;
                end else begin
                    n_x = w_row.fail; n_state = S_B_GX;
                end
            end
            S_B_FRD: begin
                n_fm = w_row.match;
                m_raddr = r_c;
                n_state = S_B_NROW;
            end
            S_B_NROW: begin
                v_msum = {1'b0, r_fm} + (MATCH_W+1)'(w_row.endm);
                v_row = w_row;
                v_row.fail = r_f;
                v_row.match = v_msum[MATCH_W] ? '1 : v_msum[MATCH_W-1:0];
                m_we = 1'b1; m_waddr = r_c; m_wdata = ROW_W'(v_row);
                if (r_tail < NC_W'(MAX_NODES)) begin
                    q_we = 1'b1; q_waddr = r_tail[NODE_W-1:0]; q_wdata = r_c;
                    n_tail = r_tail + NC_W'(1);
                end
                n_i = r_i + (CI_W+1)'(1);
                n_state = S_B_CHILD;
            end
            S_B_QRD: begin
                n_cur = q_rdata;
                m_raddr = q_rdata;
                n_state = S_B_CROW;
            end
            S_B_CROW: begin
                n_cur_ch = w_row.ch;
                n_cur_fail = w_row.fail;
                n_i = '0;
                n_state = S_B_CHILD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_valid <= 1'b0;
            r_node_count <= NC_W'(1);
            r_cursor <= '0;
            r_scan <= '0;
            r_total <= '0;
            r_full <= 1'b0;
            r_lost <= 1'b0;
            r_root <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_func <= FUNC_CLEAR;
        end else begin
            r_state <= n_state;
            r_o_valid <= n_o_valid;
            r_node_count <= n_node_count;
            r_cursor <= n_cursor;
            r_scan <= n_scan;
            r_total <= n_total;
            r_full <= n_full;
            r_lost <= n_lost;
            r_root <= n_root;
            r_head <= n_head;
            r_tail <= n_tail;
            r_func <= n_func;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_m <= n_out_m;
        r_out_done <= n_out_done;
        r_sym <= n_sym;
        r_last <= n_last;
        r_x <= n_x;
        r_c <= n_c;
        r_cur <= n_cur;
        r_cur_fail <= n_cur_fail;
        r_f <= n_f;
        r_fm <= n_fm;
        r_cur_ch <= n_cur_ch;
        r_i <= n_i;
        r_prow <= n_prow;
    end

    a_node_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_node_count >= NC_W'(1)) && (r_node_count <= NC_W'(MAX_NODES)))
        else $error("node count out of range");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_func == FUNC_CLEAR) |=>
        (r_node_count == NC_W'(1)) && (r_total == '0) && !r_full)
        else $error("clear did not reset trie state");

    a_nonscan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func != FUNC_SCAN) |-> (o_matches_here == '0))
        else $error("non-scan item reported matches");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_head <= r_tail) && (r_tail <= NC_W'(MAX_NODES)))
        else $error("build queue pointers crossed");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("item accepted while busy");
endmodule
`default_nettype wire

[sim/tb_aho_corasick_dna_matcher.sv]
// tb_aho_corasick_dna_matcher: self-checking bench for the dna pattern matcher
// depends on acdm_pkg and the aho_corasick_dna_matcher rtl
`timescale 1ns / 1ps
module tb_aho_corasick_dna_matcher;
    import acdm_pkg::*;

    localparam int NODES = MAX_NODES_DEF;
    localparam int ALPHA = ALPHA_DEF;
    localparam int IDLE_LIMIT = 500000;

    typedef struct packed {
        logic [MATCH_W-1:0] hits;
        logic [TOTAL_W-1:0] total;
        logic               full;
        logic               done;
    } match_res_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  sym;
        logic              last;
        logic              typed;
        match_res_t        res;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic [FUNC_W-1:0] i_func;
    logic [SYM_W-1:0] i_symbol;
    logic i_last_of_pattern;
    logic o_valid;
    logic i_ready;
    logic [MATCH_W-1:0] o_matches_here;
    logic [TOTAL_W-1:0] o_running_total;
    logic o_table_full;
    logic o_done_res;

    aho_corasick_dna_matcher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_symbol(i_symbol), .i_last_of_pattern(i_last_of_pattern),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_matches_here(o_matches_here), .o_running_total(o_running_total),
        .o_table_full(o_table_full), .o_done_res(o_done_res)
    );

    // trie mirror
    logic [11:0] trie_child [NODES][ALPHA];
    logic [11:0] fail_to [NODES];
    logic [7:0]  suffix_hits [NODES];
    logic        ends_here [NODES];
    logic [11:0] walk_queue [NODES];
    int unsigned node_cnt;
    logic [11:0] ins_node;
    logic [11:0] text_node;
    logic [31:0] hit_total;
    logic        trie_full;
    logic        pattern_dropped;

    match_res_t pending_res [$];
    int fails;
    int idle_cycles;
    int burst_left;
    bit hold_req;

    function automatic logic [11:0] next_state(logic [11:0] start, int sym);
        logic [11:0] x;
        int guard;
        x = start;
        guard = 0;
        while (x != 0 && trie_child[x][sym] == 0 && guard < NODES) begin
            x = fail_to[x];
            guard++;
        end
        if (trie_child[x][sym] != 0) x = trie_child[x][sym];
        return x;
    endfunction

    function automatic void trie_clear();
        for (int n = 0; n < NODES; n++) begin
            for (int s = 0; s < ALPHA; s++) trie_child[n][s] = '0;
            fail_to[n] = '0;
            suffix_hits[n] = '0;
            ends_here[n] = 1'b0;
        end
        node_cnt = 1;
        ins_node = '0;
        text_node = '0;
        hit_total = '0;
        trie_full = 1'b0;
        pattern_dropped = 1'b0;
    endfunction

    function automatic logic trie_insert(int sym, logic last);
        logic [11:0] nxt;
        if (pattern_dropped) begin
            if (last) begin
                pattern_dropped = 1'b0;
                ins_node = '0;
            end
            return 1'b0;
        end
        nxt = trie_child[ins_node][sym];
        if (nxt == 0) begin
            if (node_cnt >= NODES) begin
                trie_full = 1'b1;
                ins_node = '0;
                pattern_dropped = !last;
                return 1'b0;
            end
            nxt = node_cnt[11:0];
            node_cnt++;
            for (int s = 0; s < ALPHA; s++) trie_child[nxt][s] = '0;
            fail_to[nxt] = '0;
            suffix_hits[nxt] = '0;
            ends_here[nxt] = 1'b0;
            trie_child[ins_node][sym] = nxt;
        end
        if (last) begin
            ends_here[nxt] = 1'b1;
            ins_node = '0;
        end else begin
            ins_node = nxt;
        end
        return 1'b1;
    endfunction

    function automatic void trie_build_links();
        int head;
        int tail;
        logic [11:0] cur;
        logic [11:0] nxt;
        logic [11:0] f;
        int sum;
        head = 0;
        tail = 0;
        fail_to[0] = '0;
        suffix_hits[0] = {7'd0, ends_here[0]};
        walk_queue[tail++] = '0;
        while (head < tail) begin
            cur = walk_queue[head++];
            for (int s = 0; s < ALPHA; s++) begin
                nxt = trie_child[cur][s];
                if (nxt != 0) begin
                    f = (cur == 0) ? 12'd0 : next_state(fail_to[cur], s);
                    fail_to[nxt] = f;
                    sum = ends_here[nxt] + suffix_hits[f];
                    suffix_hits[nxt] = (sum > 255) ? 8'd255 : sum[7:0];
                    if (tail < NODES) walk_queue[tail++] = nxt;
                end
            end
        end
        text_node = '0;
    endfunction

    function automatic match_res_t predict_match(logic [1:0] func, logic [1:0] sym,
                                                logic last);
        match_res_t r;
        r.hits = '0;
        r.done = 1'b1;
        case (func)
            FUNC_CLEAR: trie_clear();
            FUNC_INSERT: r.done = trie_insert(sym, last);
            FUNC_BUILD: trie_build_links();
            default: begin
                text_node = next_state(text_node, sym);
                r.hits = suffix_hits[text_node];
                if (hit_total > 32'hFFFF_FFFF - r.hits) hit_total = 32'hFFFF_FFFF;
                else hit_total = hit_total + r.hits;
            end
        endcase
        r.total = hit_total;
        r.full = trie_full;
        return r;
    endfunction

    // offers one item; entered and left at a falling edge
    task automatic send_item(logic [1:0] func, logic [1:0] sym, logic last,
                             logic typed = 1'b0, match_res_t typed_res = '0);
        match_res_t r;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_symbol <= sym;
        i_last_of_pattern <= last;
        do @(posedge i_clk); while (!o_ready);
        r = predict_match(func, sym, last);
        pending_res = {pending_res, (typed ? typed_res : r)};
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_pattern(int len, int sym_hi);
        for (int k = 0; k < len; k++)
            send_item(FUNC_INSERT, 2'($urandom_range(0, sym_hi)), k == len - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
    endtask

    stim_row_t directed [] = '{
        '{FUNC_SCAN,   2'd0, 1'b0, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}},
        '{FUNC_INSERT, 2'd0, 1'b1, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}},
        '{FUNC_INSERT, 2'd0, 1'b0, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}},
        '{FUNC_INSERT, 2'd1, 1'b1, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}},
        '{FUNC_INSERT, 2'd1, 1'b0, 1'b0, '0},
        '{FUNC_INSERT, 2'd0, 1'b1, 1'b0, '0},
        '{FUNC_INSERT, 2'd0, 1'b1, 1'b0, '0},
        '{FUNC_INSERT, 2'd3, 1'b0, 1'b0, '0},
        '{FUNC_INSERT, 2'd2, 1'b1, 1'b0, '0},
        '{FUNC_SCAN,   2'd0, 1'b0, 1'b0, '0},
        '{FUNC_BUILD,  2'd3, 1'b1, 1'b0, '0},
        '{FUNC_SCAN,   2'd0, 1'b0, 1'b0, '0},
        '{FUNC_SCAN,   2'd1, 1'b1, 1'b0, '0},
        '{FUNC_SCAN,   2'd0, 1'b0, 1'b0, '0},
        '{FUNC_SCAN,   2'd3, 1'b0, 1'b0, '0},
        '{FUNC_SCAN,   2'd2, 1'b0, 1'b0, '0},
        '{FUNC_INSERT, 2'd2, 1'b1, 1'b0, '0},
        '{FUNC_SCAN,   2'd2, 1'b0, 1'b0, '0},
        '{FUNC_BUILD,  2'd0, 1'b0, 1'b0, '0},
        '{FUNC_BUILD,  2'd0, 1'b0, 1'b0, '0},
        '{FUNC_SCAN,   2'd2, 1'b0, 1'b0, '0},
        '{FUNC_CLEAR,  2'd1, 1'b1, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}},
        '{FUNC_SCAN,   2'd0, 1'b0, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b1}}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls
    initial begin
        int cyc;
        i_ready = 1'b0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            case ((cyc / 64) % 3)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= (cyc % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        match_res_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result m=%0d t=%0d f=%0b d=%0b", $time,
                         o_matches_here, o_running_total, o_table_full, o_done_res);
                fails++;
            end else begin
                want = pending_res.pop_front();
                if (o_matches_here !== want.hits) begin
                    $display("%0t: matches_here exp %0d got %0d", $time, want.hits,
                             o_matches_here);
                    fails++;
                end
                if (o_running_total !== want.total) begin
                    $display("%0t: running_total exp %0d got %0d", $time, want.total,
                             o_running_total);
                    fails++;
                end
                if (o_table_full !== want.full) begin
                    $display("%0t: table_full exp %0b got %0b", $time, want.full,
                             o_table_full);
                    fails++;
                end
                if (o_done_res !== want.done) begin
                    $display("%0t: done_res exp %0b got %0b", $time, want.done, o_done_res);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_aho_corasick_dna_matcher NOT OK");
            $finish;
        end
    end

    initial begin
        int sent;
        int pick;
        bit held;
        fails = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_req = 1'b0;
        held = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_CLEAR;
        i_symbol = '0;
        i_last_of_pattern = 1'b0;
        trie_clear();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k])
            send_item(directed[k].func, directed[k].sym, directed[k].last,
                      directed[k].typed, directed[k].res);

        // random: mostly patterns, builds and scan runs over a biased alphabet
        sent = 0;
        while (sent < 1200) begin
            if (sent > 500 && !held) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_item(FUNC_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 33) begin
                pick = $urandom_range(1, 6);
                send_pattern(pick, ($urandom_range(0, 1) != 0) ? 1 : 3);
                sent += pick;
            end else if (pick < 43) begin
                send_item(FUNC_BUILD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 88) begin
                pick = $urandom_range(5, 30);
                for (int k = 0; k < pick; k++)
                    send_item(FUNC_SCAN,
                              2'($urandom_range(0, ($urandom_range(0, 3) != 0) ? 1 : 3)),
                              1'($urandom_range(0, 1)));
                sent += pick;
            end else begin
                send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (fails == 0) begin
            $display("tb_aho_corasick_dna_matcher OK");
        end else begin
            $display("tb_aho_corasick_dna_matcher NOT OK");
        end
        $finish;
    end
endmodule
